// ----- src/delimited_token_splitter_unit_assert.svh -----
// Assertion macros for the token splitter.
`ifndef DELIMITED_TOKEN_SPLITTER_UNIT_ASSERT_SVH
`define DELIMITED_TOKEN_SPLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("dts check failed");
`define DTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dts check failed");
`else
`define DTS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/dts_pkg.sv -----
package dts_pkg;

	typedef enum logic [1:0] {
		STATUS_MORE  = 2'd0,
		STATUS_FINAL = 2'd1,
		STATUS_NONE  = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] token_offset;
		logic [15:0] token_length;
		logic [15:0] delimiter_offset;
		status_t     status;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic [7:0] delim_a;
		logic [7:0] delim_b;
		logic [7:0] delim_c;
		logic [7:0] skip_a;
		logic [7:0] skip_b;
	} cfg_t;

	localparam logic [2:0] REG_DELIM_A = 3'd0;
	localparam logic [2:0] REG_DELIM_B = 3'd1;
	localparam logic [2:0] REG_DELIM_C = 3'd2;
	localparam logic [2:0] REG_SKIP_A  = 3'd3;
	localparam logic [2:0] REG_SKIP_B  = 3'd4;

	localparam logic [7:0] RESET_DELIM_A = 8'd44;
	localparam logic [7:0] RESET_DELIM_B = 8'd59;
	localparam logic [7:0] RESET_DELIM_C = 8'd10;
	localparam logic [7:0] RESET_SKIP_A  = 8'd32;
	localparam logic [7:0] RESET_SKIP_B  = 8'd9;

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_CNT_BITS = 3;

endpackage

// ----- src/dts_cfg.sv -----
module dts_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [2:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output dts_pkg::cfg_t cfg
);
	import dts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_a <= RESET_DELIM_A;
			cfg_q.delim_b <= RESET_DELIM_B;
			cfg_q.delim_c <= RESET_DELIM_C;
			cfg_q.skip_a  <= RESET_SKIP_A;
			cfg_q.skip_b  <= RESET_SKIP_B;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DELIM_A: cfg_q.delim_a <= cfg_data;
				REG_DELIM_B: cfg_q.delim_b <= cfg_data;
				REG_DELIM_C: cfg_q.delim_c <= cfg_data;
				REG_SKIP_A:  cfg_q.skip_a  <= cfg_data;
				REG_SKIP_B:  cfg_q.skip_b  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/dts_core.sv -----
module dts_core #(
	parameter int OFFSET_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             end_of_source,
	input  dts_pkg::cfg_t    cfg,
	output logic             push0,
	output logic             push1,
	output dts_pkg::result_t res0,
	output dts_pkg::result_t res1
);
	import dts_pkg::*;

	localparam int W = OFFSET_BITS;

	logic [W-1:0] pos_q, start_q, len_q, dpos_q;
	logic         after_q, fin_q;
	logic [W-1:0] pos_n, start_n, len_n, dpos_n;
	logic         after_n, fin_n;
	logic [W-1:0] pos_inc, t_start, t_len;
	logic         is_skip, is_delim;

	function automatic result_t end_res(input logic [W-1:0] s, input logic [W-1:0] l);
		result_t r;
		r = '0;
		if (l == '0) begin
			r.status = STATUS_NONE;
		end else begin
			r.token_offset = 16'(s);
			r.token_length = 16'(l);
			r.status       = STATUS_FINAL;
		end
		r.last_result = 1'b1;
		return r;
	endfunction

	assign pos_inc  = pos_q + W'(1);
	assign is_skip  = (data_byte == cfg.skip_a) || (data_byte == cfg.skip_b);
	assign is_delim = (data_byte == cfg.delim_a) || (data_byte == cfg.delim_b)
		|| (data_byte == cfg.delim_c);

	always_comb begin
		pos_n   = pos_q;
		start_n = start_q;
		len_n   = len_q;
		dpos_n  = dpos_q;
		after_n = after_q;
		fin_n   = fin_q;
		push0   = 1'b0;
		push1   = 1'b0;
		res0    = '0;
		res1    = '0;
		t_start = start_q;
		t_len   = len_q;
		if (step) begin
			if (fin_q) begin
				pos_n = pos_inc;
			end else if (after_q && is_skip) begin
				pos_n = pos_inc;
				if (end_of_source) begin
					push0 = 1'b1;
					res0  = end_res(start_q, len_q);
				end
			end else if (after_q && (len_q == '0)) begin
				push0              = 1'b1;
				res0.status        = STATUS_NONE;
				res0.last_result   = 1'b1;
				fin_n              = 1'b1;
				pos_n              = pos_inc;
			end else begin
				if (after_q) begin
					push0                 = 1'b1;
					res0.token_offset     = 16'(start_q);
					res0.token_length     = 16'(len_q);
					res0.delimiter_offset = 16'(dpos_q);
					res0.status           = STATUS_MORE;
					res0.last_result      = 1'b1;
					t_start               = pos_q;
					t_len                 = '0;
					after_n               = 1'b0;
					dpos_n                = '0;
				end
				if (is_delim) begin
					dpos_n  = pos_q;
					after_n = 1'b1;
				end else if (!is_skip) begin
					t_len = pos_inc - t_start;
				end
				start_n = t_start;
				len_n   = t_len;
				pos_n   = pos_inc;
				if (end_of_source) begin
					if (after_q) begin
						push1            = 1'b1;
						res1             = end_res(t_start, t_len);
						res0.last_result = 1'b0;
					end else begin
						push0 = 1'b1;
						res0  = end_res(t_start, t_len);
					end
				end
			end
			if (end_of_source) begin
				pos_n   = '0;
				start_n = '0;
				len_n   = '0;
				dpos_n  = '0;
				after_n = 1'b0;
				fin_n   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			dpos_q  <= '0;
			after_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			pos_q   <= pos_n;
			start_q <= start_n;
			len_q   <= len_n;
			dpos_q  <= dpos_n;
			after_q <= after_n;
			fin_q   <= fin_n;
		end
	end

endmodule

// ----- src/dts_fifo.sv -----
module dts_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push0,
	input  logic                                push1,
	input  dts_pkg::result_t                    din0,
	input  dts_pkg::result_t                    din1,
	input  logic                                pop,
	output dts_pkg::result_t                    dout,
	output logic [dts_pkg::FIFO_CNT_BITS-1:0]   count
);
	import dts_pkg::*;

	result_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q, rd_q, wr_next;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	assign wr_next = wr_q + FIFO_PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem[wr_q] <= din0;
		end
		if (push1) begin
			mem[wr_next] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_BITS'(push0) + FIFO_PTR_BITS'(push1);
			rd_q  <= rd_q + FIFO_PTR_BITS'(pop);
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push0) + FIFO_CNT_BITS'(push1)
				- FIFO_CNT_BITS'(pop);
		end
	end

	assign dout  = mem[rd_q];
	assign count = cnt_q;

endmodule

// ----- src/delimited_token_splitter_unit.sv -----
// Delimited token splitter.
// Input channel (in_valid/in_ready): one source byte per transfer, with
// end_of_source marking the final byte. Output channel (out_valid/out_ready):
// one token result per transfer; a byte may produce zero, one or two results,
// and last_result flags the final one produced by that byte.
// Configuration: cfg_write with cfg_index/cfg_data sets the three delimiter
// and two skip bytes; write only while no byte is in flight.
// Path: a byte is captured in the input register, evaluated from there by the
// core, and its results are written to the output queue, from which they transfer.
// Throughput: one byte per cycle while the queue has room. A byte that yields
// two results hands them out one per transfer; results wait in a four-entry
// queue, and input is taken while the queue has room for two more results.
// Output stall: once the queue has room for fewer than two results, the input
// register holds and in_ready drops until the receiver drains results.
// Reset: clears the queue, the input register and the token state to
// offset 0; configuration returns to delimiters 44, 59, 10 and skips 32, 9.
`include "delimited_token_splitter_unit_assert.svh"

module delimited_token_splitter_unit #(
	parameter int OFFSET_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         end_of_source,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [15:0]  token_offset,
	output logic [15:0]  token_length,
	output logic [15:0]  delimiter_offset,
	output logic [1:0]   status,
	output logic         last_result
);
	import dts_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1, eos_s1, advance, push0, push1, pop;
	logic [7:0]               byte_s1;
	result_t                  res0, res1, head;
	logic [FIFO_CNT_BITS-1:0] fifo_count;

	dts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_source;
		end
	end

	dts_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.end_of_source (eos_s1),
		.cfg           (cfg),
		.push0         (push0),
		.push1         (push1),
		.res0          (res0),
		.res1          (res1)
	);

	dts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.din0   (res0),
		.din1   (res1),
		.pop    (pop),
		.dout   (head),
		.count  (fifo_count)
	);

	assign out_valid        = (fifo_count != '0);
	assign pop              = out_valid && out_ready;
	assign token_offset     = head.token_offset;
	assign token_length     = head.token_length;
	assign delimiter_offset = head.delimiter_offset;
	assign status           = head.status;
	assign last_result      = head.last_result;

	`DTS_ASSERT_ALWAYS(a_fifo_bound, clk, arst_n, fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH))
	`DTS_ASSERT_IMPLY(a_second_needs_first, clk, arst_n, push1, push0 && !res0.last_result)
	`DTS_ASSERT_IMPLY(a_stall_holds_s1, clk, arst_n, !in_ready, valid_s1)
	`DTS_ASSERT_IMPLY(a_drain_by_pop, clk, arst_n, $fell(out_valid), $past(pop))

endmodule
